>>> rtl/llms_pkg.sv
// ----------------------------------------------------------------------------
// Linked list move/splice engine package
// Sizes, node numbering, command codes and shared types for the engine.
// ----------------------------------------------------------------------------
package llms_pkg;

   localparam int MAX_LISTS  = 256;
   localparam int NODE_COUNT = 3 * MAX_LISTS + 1;
   localparam int ELEM_W     = $clog2(MAX_LISTS + 1);
   localparam int NODE_W     = $clog2(NODE_COUNT);

   localparam logic [1:0] CMD_MOVE   = 2'd0;
   localparam logic [1:0] CMD_SPLICE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_RD1,
      ST_W0,
      ST_W1,
      ST_W2,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic              we;
      logic [NODE_W-1:0] waddr;
      logic [NODE_W-1:0] wdata;
      logic [NODE_W-1:0] raddr;
   } mem_port_type;

   typedef struct packed {
      logic [ELEM_W-1:0] next_element;
      logic              list_end;
   } result_type;

   function automatic logic [NODE_W-1:0] head_of(input logic [ELEM_W-1:0] i);
      return NODE_W'(MAX_LISTS) + NODE_W'(i);
   endfunction

   function automatic logic [NODE_W-1:0] tail_of(input logic [ELEM_W-1:0] i);
      return NODE_W'(2 * MAX_LISTS) + NODE_W'(i);
   endfunction

   function automatic logic [NODE_W-1:0] init_fwd(input logic [NODE_W-1:0] n);
      logic [NODE_W-1:0] r;
      r = '0;
      if (n != '0 && n <= NODE_W'(MAX_LISTS)) begin
         r = n + NODE_W'(2 * MAX_LISTS);
      end else if (n > NODE_W'(MAX_LISTS) && n <= NODE_W'(2 * MAX_LISTS)) begin
         r = n - NODE_W'(MAX_LISTS);
      end
      return r;
   endfunction

   function automatic logic [NODE_W-1:0] init_bwd(input logic [NODE_W-1:0] n);
      logic [NODE_W-1:0] r;
      r = '0;
      if (n != '0 && n <= NODE_W'(MAX_LISTS)) begin
         r = n + NODE_W'(MAX_LISTS);
      end else if (n > NODE_W'(2 * MAX_LISTS) && n <= NODE_W'(3 * MAX_LISTS)) begin
         r = n - NODE_W'(2 * MAX_LISTS);
      end
      return r;
   endfunction

endpackage

>>> rtl/linked_list_move_splice_engine.sv
// ----------------------------------------------------------------------------
// Linked list move/splice engine
// Doubly linked lists kept in forward and backward link memories.
// ----------------------------------------------------------------------------
// After reset and after every list_count write the engine sweeps both link
// memories, one node per cycle, with req_stall high; list i then holds
// element i alone. A move or splice request passes through two dependent
// read rounds, then three write rounds, then the response register; a read
// or a splice of an empty list leaves out the write rounds, and an ignored
// or no-op request goes straight to the response register. A finished result
// also waits while the response register is stalled. This order is set by the
// single read and write port of each link memory. The response register holds
// a finished result while the sequencer returns for the next request.
module linked_list_move_splice_engine import llms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [ELEM_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [ELEM_W-1:0] req_first_operand,
   input  logic [ELEM_W-1:0] req_second_operand,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ELEM_W-1:0] rsp_next_element,
   output logic              rsp_list_end
);

   logic [ELEM_W-1:0] list_count_ff, list_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   mem_port_type      fwd_port, bwd_port;
   logic [NODE_W-1:0] fwd_rdata, bwd_rdata;
   logic              rsp_free, rsp_load;
   result_type        seq_result;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      list_count_in = list_count_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            list_count_in = ELEM_W'(1);
         end else if (csr_wr_data > ELEM_W'(MAX_LISTS)) begin
            list_count_in = ELEM_W'(MAX_LISTS);
         end else begin
            list_count_in = csr_wr_data;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_count_ff <= ELEM_W'(MAX_LISTS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         list_count_ff <= list_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_element = rsp_data_ff.next_element;
   assign rsp_list_end     = rsp_data_ff.list_end;

   llms_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .restart            (csr_wr_en),
      .list_count         (list_count_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .fwd_port           (fwd_port),
      .bwd_port           (bwd_port),
      .fwd_rdata          (fwd_rdata),
      .bwd_rdata          (bwd_rdata),
      .rsp_free           (rsp_free),
      .rsp_load           (rsp_load),
      .rsp_result         (seq_result)
   );

   llms_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_fwd_ram (
      .clock   (clock),
      .wr_en   (fwd_port.we),
      .wr_addr (fwd_port.waddr),
      .wr_data (fwd_port.wdata),
      .rd_addr (fwd_port.raddr),
      .rd_data (fwd_rdata)
   );

   llms_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_bwd_ram (
      .clock   (clock),
      .wr_en   (bwd_port.we),
      .wr_addr (bwd_port.waddr),
      .wr_data (bwd_port.wdata),
      .rd_addr (bwd_port.raddr),
      .rd_data (bwd_rdata)
   );

`ifndef SYNTH
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response loaded over a pending response");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted in back-to-back cycles");

   a_csr_sweep: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (req_stall && !rsp_load))
      else $error("request path open right after list_count write");
`endif

endmodule

>>> rtl/llms_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module llms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/llms_seq.sv
// ----------------------------------------------------------------------------
// Linked list command sequencer
// Initialises the link memories, then reads links for each request and
// updates and writes back links for moves and splices.
// ----------------------------------------------------------------------------
module llms_seq import llms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  logic [ELEM_W-1:0] list_count,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [ELEM_W-1:0] req_first_operand,
   input  logic [ELEM_W-1:0] req_second_operand,
   output mem_port_type      fwd_port,
   output mem_port_type      bwd_port,
   input  logic [NODE_W-1:0] fwd_rdata,
   input  logic [NODE_W-1:0] bwd_rdata,
   input  logic              rsp_free,
   output logic              rsp_load,
   output result_type        rsp_result
);

   seq_state_type     state_ff, state_in;
   logic [NODE_W-1:0] cnt_ff, cnt_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [ELEM_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [NODE_W-1:0] f0_ff, f0_in, b0_ff, b0_in, f1_ff, f1_in, b1_ff, b1_in;
   result_type        res_ff, res_in;

   logic [NODE_W-1:0] a_node, b_node, sec_f, sec_b, succ;
   logic              in_range, op_ok;

   assign a_node = NODE_W'(a_ff);
   assign b_node = NODE_W'(b_ff);
   assign sec_f  = (state_ff == ST_W0) ? fwd_rdata : f1_ff;
   assign sec_b  = (state_ff == ST_W0) ? bwd_rdata : b1_ff;
   assign succ   = (b_node == b0_ff) ? f0_ff : sec_f;

   assign in_range = req_first_operand != '0 && req_first_operand <= list_count &&
                     req_second_operand <= list_count;
   assign op_ok    = in_range &&
                     (req_command == CMD_READ ||
                      ((req_command == CMD_MOVE || req_command == CMD_SPLICE) &&
                       req_second_operand != '0 &&
                       req_first_operand != req_second_operand));

   assign req_stall  = state_ff != ST_IDLE;
   assign rsp_result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      f0_ff  <= f0_in;
      b0_ff  <= b0_in;
      f1_ff  <= f1_in;
      b1_ff  <= b1_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd_in   = cmd_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      f0_in    = f0_ff;
      b0_in    = b0_ff;
      f1_in    = f1_ff;
      b1_in    = b1_ff;
      res_in   = res_ff;
      fwd_port = '0;
      bwd_port = '0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_INIT: begin
            fwd_port.we    = 1'b1;
            fwd_port.waddr = cnt_ff;
            fwd_port.wdata = init_fwd(cnt_ff);
            bwd_port.we    = 1'b1;
            bwd_port.waddr = cnt_ff;
            bwd_port.wdata = init_bwd(cnt_ff);
            if (cnt_ff == NODE_W'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + NODE_W'(1);
            end
         end
         ST_IDLE: begin
            case (req_command)
               CMD_SPLICE: begin
                  fwd_port.raddr = head_of(req_first_operand);
                  bwd_port.raddr = tail_of(req_first_operand);
               end
               CMD_READ: begin
                  fwd_port.raddr = (req_second_operand == '0) ?
                                   head_of(req_first_operand) :
                                   NODE_W'(req_second_operand);
               end
               default: begin
                  fwd_port.raddr = NODE_W'(req_first_operand);
                  bwd_port.raddr = NODE_W'(req_first_operand);
               end
            endcase
            if (req_valid) begin
               cmd_in   = req_command;
               a_in     = req_first_operand;
               b_in     = req_second_operand;
               res_in   = '0;
               state_in = op_ok ? ST_RD1 : ST_DONE;
            end
         end
         ST_RD1: begin
            f0_in = fwd_rdata;
            b0_in = bwd_rdata;
            case (cmd_ff)
               CMD_READ: begin
                  if (fwd_rdata > NODE_W'(2 * MAX_LISTS)) begin
                     res_in.list_end = 1'b1;
                  end else if (fwd_rdata != '0 && fwd_rdata <= NODE_W'(MAX_LISTS)) begin
                     res_in.next_element = fwd_rdata[ELEM_W-1:0];
                  end
                  state_in = ST_DONE;
               end
               CMD_SPLICE: begin
                  bwd_port.raddr = tail_of(b_ff);
                  state_in = (fwd_rdata == tail_of(a_ff)) ? ST_DONE : ST_W0;
               end
               default: begin
                  fwd_port.raddr = b_node;
                  state_in = ST_W0;
               end
            endcase
         end
         ST_W0: begin
            f1_in = fwd_rdata;
            b1_in = bwd_rdata;
            fwd_port.we = 1'b1;
            bwd_port.we = 1'b1;
            case (cmd_ff)
               CMD_SPLICE: begin
                  fwd_port.waddr = sec_b;
                  fwd_port.wdata = f0_ff;
                  bwd_port.waddr = f0_ff;
                  bwd_port.wdata = sec_b;
               end
               default: begin
                  fwd_port.waddr = b0_ff;
                  fwd_port.wdata = f0_ff;
                  bwd_port.waddr = f0_ff;
                  bwd_port.wdata = b0_ff;
               end
            endcase
            state_in = ST_W1;
         end
         ST_W1: begin
            fwd_port.we = 1'b1;
            bwd_port.we = 1'b1;
            case (cmd_ff)
               CMD_SPLICE: begin
                  fwd_port.waddr = b0_ff;
                  fwd_port.wdata = tail_of(b_ff);
                  bwd_port.waddr = tail_of(b_ff);
                  bwd_port.wdata = b0_ff;
               end
               default: begin
                  fwd_port.waddr = b_node;
                  fwd_port.wdata = a_node;
                  bwd_port.waddr = a_node;
                  bwd_port.wdata = b_node;
               end
            endcase
            state_in = ST_W2;
         end
         ST_W2: begin
            fwd_port.we = 1'b1;
            bwd_port.we = 1'b1;
            case (cmd_ff)
               CMD_SPLICE: begin
                  fwd_port.waddr = head_of(a_ff);
                  fwd_port.wdata = tail_of(a_ff);
                  bwd_port.waddr = tail_of(a_ff);
                  bwd_port.wdata = head_of(a_ff);
               end
               default: begin
                  fwd_port.waddr = a_node;
                  fwd_port.wdata = succ;
                  bwd_port.waddr = succ;
                  bwd_port.wdata = a_node;
               end
            endcase
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
            cnt_in   = '0;
         end
      endcase
      if (restart) begin
         state_in = ST_INIT;
         cnt_in   = '0;
      end
   end

endmodule
